[src/cdc_pkg.sv]
package cdc_pkg;

    // Command codes
    localparam logic [1:0] CMD_SET  = 2'd0;
    localparam logic [1:0] CMD_INC  = 2'd1;
    localparam logic [1:0] CMD_DEC  = 2'd2;
    localparam logic [1:0] CMD_CMP  = 2'd3;

    // Status codes
    localparam logic [2:0] STAT_OK        = 3'd0;
    localparam logic [2:0] STAT_EARLY     = 3'd1;
    localparam logic [2:0] STAT_BAD_DATE  = 3'd2;
    localparam logic [2:0] STAT_AT_BASE   = 3'd3;
    localparam logic [2:0] STAT_OVERFLOW  = 3'd4;

    localparam logic [15:0] CDC_BASE_YEAR = 16'd1970;
    localparam logic [15:0] CDC_YEAR_MAX  = 16'hFFFF;
    localparam logic [3:0]  CDC_DECEMBER  = 4'd12;
    localparam logic [3:0]  CDC_FEBRUARY  = 4'd2;
    localparam logic [4:0]  CDC_LAST_DAY  = 5'd31;
    localparam logic [4:0]  CDC_FEB_LEAP  = 5'd29;

    // Divisibility by 25: multiply by the inverse of 25 mod 2^16,
    // divisible exactly when the product lands at or below 65535 / 25
    localparam logic [15:0] CDC_INV25     = 16'd23593;
    localparam logic [15:0] CDC_DIV25_MAX = 16'd2621;

    localparam logic [4:0] CDC_MONTH_LEN [0:11] = '{
        5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
        5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
    };

    typedef struct packed {
        logic [1:0]  kind;
        logic [4:0]  day_in;
        logic [3:0]  month_in;
        logic [15:0] year_in;
    } cdc_req_t;

    typedef struct packed {
        logic [4:0]  day_out;
        logic [3:0]  month_out;
        logic [15:0] year_out;
        logic        leap_year;
        logic [2:0]  status;
        logic        dates_match;
    } cdc_rsp_t;

    typedef struct packed {
        logic [4:0]  day;
        logic [3:0]  month;
        logic [15:0] year;
        logic        leap;
    } cdc_date_t;

    // Leap: divisible by 400, or by 4 and not by 100
    function automatic logic leap_of(input logic [15:0] y);
        logic [15:0] prod;
        logic        div25;
        prod  = 16'(y * CDC_INV25);
        div25 = (prod <= CDC_DIV25_MAX);
        return ((y[1:0] == 2'd0) && !div25) || ((y[3:0] == 4'd0) && div25);
    endfunction

    // Month length; an out-of-range month reads as 31
    function automatic logic [4:0] days_in(input logic [3:0] m, input logic leap);
        logic [3:0] idx;
        idx = m - 4'd1;
        if (m == 4'd0 || m > CDC_DECEMBER) begin
            return CDC_LAST_DAY;
        end else if (m == CDC_FEBRUARY && leap) begin
            return CDC_FEB_LEAP;
        end else begin
            return CDC_MONTH_LEN[idx];
        end
    endfunction

endpackage

[src/cdc_date_step.sv]
module cdc_date_step import cdc_pkg::*; #(
    parameter logic [15:0] BASE_YEAR = CDC_BASE_YEAR
) (
    input  cdc_req_t  req,
    input  cdc_date_t cur,
    output cdc_date_t date_next,
    output cdc_rsp_t  rsp
);

    logic        set_leap;
    logic        set_bad;
    logic [5:0]  day_inc;
    logic        at_last;
    logic        at_base;
    logic [3:0]  dec_month;
    logic [2:0]  status;
    logic        match;
    logic        year_moved;
    cdc_date_t   nd;

    // Check a set request against the year it brings
    assign set_leap = leap_of(req.year_in);
    assign set_bad  = (req.month_in == 4'd0) || (req.month_in > CDC_DECEMBER) ||
                      (req.day_in == 5'd0) ||
                      (req.day_in > days_in(req.month_in, set_leap));

    assign day_inc   = {1'b0, cur.day} + 6'd1;
    assign at_last   = (cur.day == CDC_LAST_DAY) && (cur.month == CDC_DECEMBER) &&
                       (cur.year == CDC_YEAR_MAX);
    assign at_base   = (cur.day == 5'd1) && (cur.month == 4'd1) && (cur.year == BASE_YEAR);
    assign dec_month = (cur.month <= 4'd1) ? CDC_DECEMBER : cur.month - 4'd1;

    // Advance the date by command
    always_comb begin
        nd         = cur;
        status     = STAT_OK;
        match      = 1'b0;
        year_moved = 1'b0;
        case (req.kind)
            CMD_SET: begin
                if (req.year_in < BASE_YEAR) begin
                    status = STAT_EARLY;
                end else if (set_bad) begin
                    status = STAT_BAD_DATE;
                end else begin
                    nd.day   = req.day_in;
                    nd.month = req.month_in;
                    nd.year  = req.year_in;
                    nd.leap  = set_leap;
                end
            end
            CMD_INC: begin
                if (at_last) begin
                    status = STAT_OVERFLOW;
                end else if (day_inc > {1'b0, days_in(cur.month, cur.leap)}) begin
                    nd.day = 5'd1;
                    if (cur.month >= CDC_DECEMBER) begin
                        nd.month   = 4'd1;
                        nd.year    = cur.year + 16'd1;
                        year_moved = 1'b1;
                    end else begin
                        nd.month = cur.month + 4'd1;
                    end
                end else begin
                    nd.day = day_inc[4:0];
                end
            end
            CMD_DEC: begin
                if (at_base) begin
                    status = STAT_AT_BASE;
                end else if (cur.day <= 5'd1) begin
                    nd.month = dec_month;
                    if (cur.month <= 4'd1) begin
                        nd.year    = cur.year - 16'd1;
                        year_moved = 1'b1;
                    end
                    // December is always 31 days, so the old leap flag serves
                    nd.day = days_in(dec_month, cur.leap);
                end else begin
                    nd.day = cur.day - 5'd1;
                end
            end
            CMD_CMP: begin
                match = (req.day_in == cur.day) && (req.month_in == cur.month) &&
                        (req.year_in == cur.year);
            end
            default: begin
                nd = cur;
            end
        endcase
        if (year_moved) begin
            nd.leap = leap_of(nd.year);
        end
    end

    assign date_next = nd;

    assign rsp.day_out     = nd.day;
    assign rsp.month_out   = nd.month;
    assign rsp.year_out    = nd.year;
    assign rsp.leap_year   = nd.leap;
    assign rsp.status      = status;
    assign rsp.dates_match = match;

endmodule

[src/calendar_date_counter_unit.sv]
// Gregorian date counter with a floor at 01-01-BASE_YEAR. Each request is
// a command (set, increment day, decrement day, compare) and yields one
// response with the stored date after the command, its leap flag, a status
// code and, for compare, a match flag. A request is registered on entry,
// the date update is combinational between that register and the response
// register, and one request is taken per cycle as long as responses are
// taken. The stored date resets to 01-01-BASE_YEAR.
module calendar_date_counter_unit import cdc_pkg::*; #(
    parameter logic [15:0] BASE_YEAR = CDC_BASE_YEAR
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  cdc_req_t s_payload,
    output logic     m_valid,
    input  logic     m_ready,
    output cdc_rsp_t m_payload
);

    logic      in_valid_reg;
    cdc_req_t  in_req_reg;
    logic      out_valid_reg;
    cdc_rsp_t  out_rsp_reg;
    cdc_date_t cur_reg;
    cdc_date_t cur_next;
    cdc_rsp_t  rsp_next;
    logic      out_free;

    assign out_free = !out_valid_reg || m_ready;
    assign s_ready  = !in_valid_reg || out_free;

    cdc_date_step #(
        .BASE_YEAR (BASE_YEAR)
    ) u_step (
        .req       (in_req_reg),
        .cur       (cur_reg),
        .date_next (cur_next),
        .rsp       (rsp_next)
    );

    // Hold the request, advance it into the response and commit the date
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            cur_reg.day   <= 5'd1;
            cur_reg.month <= 4'd1;
            cur_reg.year  <= BASE_YEAR;
            cur_reg.leap  <= leap_of(BASE_YEAR);
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (out_free) begin
                out_valid_reg <= in_valid_reg;
                if (in_valid_reg) begin
                    cur_reg <= cur_next;
                end
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_req_reg <= s_payload;
        end
        if (out_free && in_valid_reg) begin
            out_rsp_reg <= rsp_next;
        end
    end

    assign m_valid   = out_valid_reg;
    assign m_payload = out_rsp_reg;

endmodule
